/* rtl/clbm_pkg.sv */
package clbm_pkg;

   localparam int IDX_W = 10;
   localparam int CMD_W = 2;
   localparam int EXT_W = 17;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_MOVE   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_MOVE   = 2'd2,
      KIND_IGNORE = 2'd3
   } kind_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } link_type;

   localparam link_type LINK_NONE = '0;

   typedef enum logic [6:0] {
      ST_CLEAR    = 7'b0000001,
      ST_IDLE     = 7'b0000010,
      ST_UNLINK   = 7'b0000100,
      ST_RD_NEW   = 7'b0001000,
      ST_INS_HEAD = 7'b0010000,
      ST_INS_LINK = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic unlink;
      logic rd_new;
      logic ins_head;
      logic ins_link;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic     clear_last;
      kind_type req_kind;
      kind_type kind;
   } dp_status_type;

endpackage

/* rtl/clbm_req_if.sv */
interface clbm_req_if import clbm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [IDX_W-1:0] particle;
   logic [IDX_W-1:0] box;
   logic [IDX_W-1:0] new_box;

   modport source (output valid, output command, output particle, output box,
                   output new_box, input ready);
   modport sink   (input valid, input command, input particle, input box,
                   input new_box, output ready);
endinterface

/* rtl/clbm_rsp_if.sv */
interface clbm_rsp_if import clbm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             head_valid;
   logic [IDX_W-1:0] head_particle;
   logic             old_box_empty;

   modport source (output valid, output head_valid, output head_particle,
                   output old_box_empty, input ready);
   modport sink   (input valid, input head_valid, input head_particle,
                   input old_box_empty, output ready);
endinterface

/* rtl/clbm_ctrl.sv */
module clbm_ctrl import clbm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (status.req_kind)
                  KIND_INSERT: state_in = ST_INS_HEAD;
                  KIND_REMOVE: state_in = ST_UNLINK;
                  KIND_MOVE:   state_in = ST_UNLINK;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = (status.kind == KIND_MOVE) ? ST_RD_NEW : ST_DONE;
         end
         ST_RD_NEW: begin
            cmd.rd_new = 1'b1;
            state_in   = ST_INS_HEAD;
         end
         ST_INS_HEAD: begin
            cmd.ins_head = 1'b1;
            state_in     = ST_INS_LINK;
         end
         ST_INS_LINK: begin
            cmd.ins_link = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/clbm_dp.sv */
module clbm_dp import clbm_pkg::*; #(
   parameter int PARTICLE_COUNT = 1024,
   parameter int BOX_COUNT      = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   output dp_status_type    status,
   input  logic [CMD_W-1:0] req_command,
   input  logic [IDX_W-1:0] req_particle,
   input  logic [IDX_W-1:0] req_box,
   input  logic [IDX_W-1:0] req_new_box,
   output logic             rsp_head_valid,
   output logic [IDX_W-1:0] rsp_head_particle,
   output logic             rsp_old_box_empty
);

   localparam int P_AW = $clog2(PARTICLE_COUNT);
   localparam int B_AW = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1;
   localparam logic [EXT_W-1:0] P_LIM  = EXT_W'(PARTICLE_COUNT);
   localparam logic [EXT_W-1:0] B_LIM  = EXT_W'(BOX_COUNT);
   localparam logic [B_AW-1:0]  B_LAST = B_AW'(BOX_COUNT - 1);

   function automatic logic [EXT_W-1:0] ext(input logic [IDX_W-1:0] v);
      return {{(EXT_W-IDX_W){1'b0}}, v};
   endfunction

   function automatic logic [P_AW-1:0] p_addr(input logic [IDX_W-1:0] v);
      logic [EXT_W-1:0] w;
      w = ext(v);
      return w[P_AW-1:0];
   endfunction

   function automatic logic [B_AW-1:0] b_addr(input logic [IDX_W-1:0] v);
      logic [EXT_W-1:0] w;
      w = ext(v);
      return w[B_AW-1:0];
   endfunction

   function automatic logic link_ok(input link_type l);
      return l.valid && (ext(l.idx) < P_LIM);
   endfunction

   link_type head_mem [BOX_COUNT];
   link_type next_mem [PARTICLE_COUNT];
   link_type prev_mem [PARTICLE_COUNT];

   link_type head_rd_ff, next_rd_ff, prev_rd_ff;

   logic            head_we, head_re;
   logic [B_AW-1:0] head_wa, head_ra;
   link_type        head_wd;
   logic            next_we, next_re;
   logic [P_AW-1:0] next_wa, next_ra;
   link_type        next_wd;
   logic            prev_we, prev_re;
   logic [P_AW-1:0] prev_wa, prev_ra;
   link_type        prev_wd;

   logic [B_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   kind_type         kind_ff, kind_in, req_kind;
   logic [IDX_W-1:0] part_ff, part_in;
   logic [IDX_W-1:0] box_ff, box_in;
   logic [IDX_W-1:0] nbox_ff, nbox_in;
   logic             box_ok_ff, box_ok_in;
   link_type         res_head_ff, res_head_in;
   logic             empty_ff, empty_in;
   link_type         out_head_ff, out_head_in;
   logic             out_empty_ff, out_empty_in;

   logic             p_ok, b_ok, nb_ok;
   logic             is_head;
   link_type         me, new_head, sel;
   logic [IDX_W-1:0] tgt_box;

   always_comb begin
      p_ok  = ext(req_particle) < P_LIM;
      b_ok  = ext(req_box) < B_LIM;
      nb_ok = ext(req_new_box) < B_LIM;
      case (req_command)
         CMD_INSERT: req_kind = (p_ok && b_ok) ? KIND_INSERT : KIND_IGNORE;
         CMD_REMOVE: req_kind = (p_ok && b_ok) ? KIND_REMOVE : KIND_IGNORE;
         CMD_MOVE:   req_kind = (p_ok && b_ok && nb_ok && (req_new_box != req_box)) ?
                                KIND_MOVE : KIND_IGNORE;
         default:    req_kind = KIND_IGNORE;
      endcase
   end

   always_comb begin
      me       = '{valid: 1'b1, idx: part_ff};
      tgt_box  = (kind_ff == KIND_MOVE) ? nbox_ff : box_ff;
      is_head  = head_rd_ff.valid && (head_rd_ff.idx == part_ff);
      new_head = is_head ? next_rd_ff : head_rd_ff;
   end

   always_comb begin
      head_we = 1'b0;
      head_wa = '0;
      head_wd = LINK_NONE;
      head_re = 1'b0;
      head_ra = '0;
      next_we = 1'b0;
      next_wa = '0;
      next_wd = LINK_NONE;
      next_re = 1'b0;
      next_ra = '0;
      prev_we = 1'b0;
      prev_wa = '0;
      prev_wd = LINK_NONE;
      prev_re = 1'b0;
      prev_ra = '0;
      if (cmd.clear) begin
         head_we = 1'b1;
         head_wa = clr_cnt_ff;
      end
      if (cmd.accept) begin
         head_re = 1'b1;
         head_ra = b_addr(req_box);
         next_re = 1'b1;
         next_ra = p_addr(req_particle);
         prev_re = 1'b1;
         prev_ra = p_addr(req_particle);
      end
      if (cmd.unlink) begin
         if (is_head) begin
            head_we = 1'b1;
            head_wa = b_addr(box_ff);
            head_wd = next_rd_ff;
         end else if (link_ok(prev_rd_ff)) begin
            next_we = 1'b1;
            next_wa = p_addr(prev_rd_ff.idx);
            next_wd = next_rd_ff;
         end
         if (link_ok(next_rd_ff)) begin
            prev_we = 1'b1;
            prev_wa = p_addr(next_rd_ff.idx);
            prev_wd = is_head ? LINK_NONE : prev_rd_ff;
         end
      end
      if (cmd.rd_new) begin
         head_re = 1'b1;
         head_ra = b_addr(nbox_ff);
      end
      if (cmd.ins_head) begin
         head_we = 1'b1;
         head_wa = b_addr(tgt_box);
         head_wd = me;
         next_we = 1'b1;
         next_wa = p_addr(part_ff);
         next_wd = head_rd_ff;
         prev_we = 1'b1;
         prev_wa = p_addr(part_ff);
      end
      if (cmd.ins_link && link_ok(head_rd_ff)) begin
         prev_we = 1'b1;
         prev_wa = p_addr(head_rd_ff.idx);
         prev_wd = me;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      if (head_re) begin
         head_rd_ff <= head_mem[head_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (next_re) begin
         next_rd_ff <= next_mem[next_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (prev_re) begin
         prev_rd_ff <= prev_mem[prev_ra];
      end
   end

   always_comb begin
      clr_cnt_in   = cmd.clear ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      kind_in      = cmd.accept ? req_kind : kind_ff;
      part_in      = cmd.accept ? req_particle : part_ff;
      box_in       = cmd.accept ? req_box : box_ff;
      nbox_in      = cmd.accept ? req_new_box : nbox_ff;
      box_ok_in    = cmd.accept ? b_ok : box_ok_ff;
      res_head_in  = res_head_ff;
      empty_in     = empty_ff;
      if (cmd.accept) begin
         empty_in = 1'b0;
      end
      if (cmd.unlink) begin
         res_head_in = new_head;
         empty_in    = !new_head.valid;
      end
      if (cmd.ins_head) begin
         res_head_in = me;
      end
      sel = res_head_ff;
      if (kind_ff == KIND_IGNORE) begin
         sel = box_ok_ff ? head_rd_ff : LINK_NONE;
      end
      out_head_in  = out_head_ff;
      out_empty_in = out_empty_ff;
      if (cmd.load_out) begin
         out_head_in  = sel.valid ? sel : LINK_NONE;
         out_empty_in = empty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      part_ff      <= part_in;
      box_ff       <= box_in;
      nbox_ff      <= nbox_in;
      box_ok_ff    <= box_ok_in;
      res_head_ff  <= res_head_in;
      empty_ff     <= empty_in;
      out_head_ff  <= out_head_in;
      out_empty_ff <= out_empty_in;
   end

   assign status.clear_last = (clr_cnt_ff == B_LAST);
   assign status.req_kind   = req_kind;
   assign status.kind       = kind_ff;

   assign rsp_head_valid    = out_head_ff.valid;
   assign rsp_head_particle = out_head_ff.idx;
   assign rsp_old_box_empty = out_empty_ff;

endmodule

/* rtl/cell_list_bucket_maintenance.sv */
// Cell list keeper: per box the first particle, per particle its neighbours
// in the same box as doubly linked lists.
// req_ch beat: command (insert, remove, move), particle, box, new_box.
// rsp_ch beat: head of the box touched last (head_valid, head_particle) and
// whether the box left by remove or move is now empty.
// One request in flight at a time; each request gives exactly one response.
// Each request steps through states set by the accesses to the head, next and
// prev link memories, each with one read and one write port: insert takes
// INS_HEAD and INS_LINK, remove takes UNLINK, move takes UNLINK, RD_NEW,
// INS_HEAD and INS_LINK, and a rejected or unknown command none; every request
// then ends in DONE, which loads the response beat into the output register.
// After reset the block sweeps the head memory to empty, one box a cycle,
// from box 0 up to box BOX_COUNT-1, with req_ch.ready low.
// A stalled rsp_ch holds the finished beat in its output register; the next
// request is still taken and worked on, and waits only to hand over its own
// response until the held beat is gone.
module cell_list_bucket_maintenance import clbm_pkg::*; #(
   parameter int PARTICLE_COUNT = 1024,
   parameter int BOX_COUNT      = 1024
) (
   input logic         clock,
   input logic         reset,
   clbm_req_if.sink    req_ch,
   clbm_rsp_if.source  rsp_ch
);

   dp_cmd_type    cmd;
   dp_status_type status;

   clbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   clbm_dp #(
      .PARTICLE_COUNT (PARTICLE_COUNT),
      .BOX_COUNT      (BOX_COUNT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_command       (req_ch.command),
      .req_particle      (req_ch.particle),
      .req_box           (req_ch.box),
      .req_new_box       (req_ch.new_box),
      .rsp_head_valid    (rsp_ch.head_valid),
      .rsp_head_particle (rsp_ch.head_particle),
      .rsp_old_box_empty (rsp_ch.old_box_empty)
   );

endmodule

/* rtl/clbm_chk.sv */
module clbm_chk import clbm_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_head_valid,
   input logic [IDX_W-1:0] rsp_head_particle
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ports not quiet after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another in flight");

   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_head_valid |-> rsp_head_particle == '0)
      else $error("empty box reports a particle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_head_particle))
      else $error("stalled response beat changed");

endmodule

bind cell_list_bucket_maintenance clbm_chk u_clbm_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_head_valid    (rsp_ch.head_valid),
   .rsp_head_particle (rsp_ch.head_particle)
);

/* tb/cell_list_bucket_maintenance_test.sv */
module cell_list_bucket_maintenance_test;
   import clbm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELL_SLOTS = 1 << IDX_W;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 16;
   localparam int RANDOM_ITEMS = 1100;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic FIXED = 1'b1;
   localparam logic PREDICT = 1'b0;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [IDX_W-1:0] particle;
      logic [IDX_W-1:0] box;
      logic [IDX_W-1:0] new_box;
   } cell_request;

   typedef struct packed {
      logic             head_valid;
      logic [IDX_W-1:0] head_particle;
      logic             old_box_empty;
   } box_report;

   typedef struct packed {
      cell_request req;
      logic        fixed;
      box_report   want;
   } bench_row;

   localparam bench_row DIRECTED_ROWS [0:20] = '{
      {CMD_UNUSED, 10'd1023, 10'd1023, 10'd1023, FIXED, 1'b0, 10'd0,    1'b0},
      {CMD_INSERT, 10'd0,    10'd0,    10'd0,    FIXED, 1'b1, 10'd0,    1'b0},
      {CMD_INSERT, 10'd1023, 10'd0,    10'd1023, FIXED, 1'b1, 10'd1023, 1'b0},
      {CMD_INSERT, 10'd5,    10'd0,    10'd0,    FIXED, 1'b1, 10'd5,    1'b0},
      {CMD_REMOVE, 10'd1023, 10'd0,    10'd0,    FIXED, 1'b1, 10'd5,    1'b0},
      {CMD_REMOVE, 10'd5,    10'd0,    10'd1023, FIXED, 1'b1, 10'd0,    1'b0},
      {CMD_MOVE,   10'd0,    10'd0,    10'd1023, FIXED, 1'b1, 10'd0,    1'b1},
      {CMD_MOVE,   10'd0,    10'd1023, 10'd1023, FIXED, 1'b1, 10'd0,    1'b0},
      {CMD_UNUSED, 10'd0,    10'd1023, 10'd0,    FIXED, 1'b1, 10'd0,    1'b0},
      {CMD_INSERT, 10'd682,  10'd341,  10'd0,    FIXED, 1'b1, 10'd682,  1'b0},
      {CMD_INSERT, 10'd341,  10'd682,  10'd1023, FIXED, 1'b1, 10'd341,  1'b0},
      {CMD_MOVE,   10'd341,  10'd682,  10'd341,  FIXED, 1'b1, 10'd341,  1'b1},
      {CMD_REMOVE, 10'd682,  10'd341,  10'd682,  FIXED, 1'b1, 10'd341,  1'b0},
      {CMD_REMOVE, 10'd341,  10'd341,  10'd0,    FIXED, 1'b0, 10'd0,    1'b1},
      {CMD_REMOVE, 10'd341,  10'd341,  10'd0,    FIXED, 1'b0, 10'd0,    1'b1},
      {CMD_REMOVE, 10'd0,    10'd5,    10'd0,    PREDICT, 12'd0},
      {CMD_MOVE,   10'd1023, 10'd7,    10'd0,    PREDICT, 12'd0},
      {CMD_INSERT, 10'd0,    10'd0,    10'd0,    PREDICT, 12'd0},
      {CMD_UNUSED, 10'd0,    10'd0,    10'd0,    PREDICT, 12'd0},
      {CMD_MOVE,   10'd5,    10'd1,    10'd2,    PREDICT, 12'd0},
      {CMD_INSERT, 10'd1023, 10'd1023, 10'd0,    PREDICT, 12'd0}
   };

   logic clock = 1'b0;
   logic reset;

   clbm_req_if req_ch ();
   clbm_rsp_if rsp_ch ();

   cell_list_bucket_maintenance dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   link_type  box_first   [CELL_SLOTS];
   link_type  next_in_box [CELL_SLOTS];
   link_type  prev_in_box [CELL_SLOTS];
   bit        ever_placed [CELL_SLOTS];
   int        believed_box [CELL_SLOTS];
   box_report awaited_heads [$];
   int        head_mismatches = 0;
   int        quiet_cycles = 0;
   bit        req_hurry = 1'b0;
   bit        rsp_hurry = 1'b0;

   function automatic void push_to_head(logic [IDX_W-1:0] p, logic [IDX_W-1:0] b);
      link_type old_head;
      link_type me;
      old_head = box_first[b];
      me = {1'b1, p};
      box_first[b] = me;
      prev_in_box[p] = LINK_NONE;
      next_in_box[p] = old_head;
      if (old_head.valid)
         prev_in_box[old_head.idx] = me;
   endfunction

   function automatic void detach(logic [IDX_W-1:0] p, logic [IDX_W-1:0] b);
      link_type nxt;
      link_type prv;
      nxt = next_in_box[p];
      prv = prev_in_box[p];
      if (box_first[b].valid && box_first[b].idx == p) begin
         box_first[b] = nxt;
         if (nxt.valid)
            prev_in_box[nxt.idx] = LINK_NONE;
      end else begin
         if (prv.valid)
            next_in_box[prv.idx] = nxt;
         if (nxt.valid)
            prev_in_box[nxt.idx] = prv;
      end
   endfunction

   function automatic box_report apply_to_cell_list(cell_request r);
      box_report rep;
      link_type shown;
      rep = '0;
      shown = box_first[r.box];
      case (r.command)
         CMD_INSERT: begin
            push_to_head(r.particle, r.box);
            shown = box_first[r.box];
         end
         CMD_REMOVE: begin
            detach(r.particle, r.box);
            shown = box_first[r.box];
            rep.old_box_empty = !shown.valid;
         end
         CMD_MOVE: begin
            if (r.new_box != r.box) begin
               detach(r.particle, r.box);
               rep.old_box_empty = !box_first[r.box].valid;
               push_to_head(r.particle, r.new_box);
               shown = box_first[r.new_box];
            end
         end
         default: ;
      endcase
      rep.head_valid = shown.valid;
      rep.head_particle = shown.valid ? shown.idx : '0;
      return rep;
   endfunction

   function automatic logic [IDX_W-1:0] pick_particle();
      if ($urandom_range(0, 9) == 0)
         return IDX_W'($urandom_range(0, CELL_SLOTS - 1));
      return IDX_W'($urandom_range(0, 63));
   endfunction

   function automatic logic [IDX_W-1:0] pick_box();
      if ($urandom_range(0, 4) == 0)
         return IDX_W'($urandom_range(0, CELL_SLOTS - 1));
      return IDX_W'($urandom_range(0, 5));
   endfunction

   function automatic cell_request next_random_request();
      cell_request r;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      r.particle = pick_particle();
      r.box = pick_box();
      r.new_box = pick_box();
      if (roll < 4) begin
         r.command = CMD_UNUSED;
         r.particle = IDX_W'($urandom_range(0, CELL_SLOTS - 1));
         r.box = IDX_W'($urandom_range(0, CELL_SLOTS - 1));
         r.new_box = IDX_W'($urandom_range(0, CELL_SLOTS - 1));
      end else if (!ever_placed[r.particle] || believed_box[r.particle] < 0) begin
         r.command = CMD_INSERT;
         believed_box[r.particle] = int'(r.box);
      end else if (roll < 7) begin
         // stray command on a placed particle, box left as drawn
         r.command = ($urandom_range(0, 1) == 0) ? CMD_REMOVE : CMD_MOVE;
      end else begin
         r.box = IDX_W'(believed_box[r.particle]);
         if (roll < 35) begin
            r.command = CMD_REMOVE;
            believed_box[r.particle] = -1;
         end else begin
            r.command = CMD_MOVE;
            if (roll < 39)
               r.new_box = r.box;
            believed_box[r.particle] = int'(r.new_box);
         end
      end
      return r;
   endfunction

   task automatic offer(input cell_request r, input logic fixed, input box_report want);
      int unsigned gap;
      box_report predicted;
      gap = req_hurry ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= r.command;
      req_ch.particle <= r.particle;
      req_ch.box <= r.box;
      req_ch.new_box <= r.new_box;
      @(posedge clock);
      while (req_ch.ready !== 1'b1)
         @(posedge clock);
      predicted = apply_to_cell_list(r);
      awaited_heads.push_back(fixed ? want : predicted);
      if (r.command == CMD_INSERT)
         ever_placed[r.particle] = 1'b1;
      @(negedge clock);
   endtask

   function automatic void flag_mismatch(string text);
      head_mismatches++;
      if (head_mismatches <= 10)
         $display("%0t mismatch: %s", $realtime, text);
   endfunction

   initial begin : stimulus
      cell_request r;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_INSERT;
      req_ch.particle = '0;
      req_ch.box = '0;
      req_ch.new_box = '0;
      for (int i = 0; i < CELL_SLOTS; i++) begin
         box_first[i] = LINK_NONE;
         next_in_box[i] = LINK_NONE;
         prev_in_box[i] = LINK_NONE;
         ever_placed[i] = 1'b0;
         believed_box[i] = -1;
      end
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIRECTED_ROWS); i++)
         offer(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0)
            req_hurry = ($urandom_range(0, 3) == 0);
         r = next_random_request();
         offer(r, PREDICT, '0);
      end
      req_ch.valid <= 1'b0;

      while (awaited_heads.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (head_mismatches == 0 && awaited_heads.size() == 0)
         $display("cell_list_bucket_maintenance_test OK");
      else
         $display("cell_list_bucket_maintenance_test NOT OK");
      $finish;
   end

   initial begin : drain
      int unsigned stall;
      int unsigned beats;
      box_report got;
      box_report want;
      beats = 0;
      rsp_ch.ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         if (beats % 64 == 0)
            rsp_hurry = ($urandom_range(0, 3) == 0);
         stall = rsp_hurry ? 0 : $urandom_range(0, 13);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1)
            @(posedge clock);
         got = {rsp_ch.head_valid, rsp_ch.head_particle, rsp_ch.old_box_empty};
         if (awaited_heads.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat valid=%0b head=%0d empty=%0b",
                                    got.head_valid, got.head_particle, got.old_box_empty));
         end else begin
            want = awaited_heads.pop_front();
            if (got.head_valid !== want.head_valid ||
                got.head_particle !== want.head_particle ||
                got.old_box_empty !== want.old_box_empty)
               flag_mismatch($sformatf(
                  "expected valid=%0b head=%0d empty=%0b, got valid=%0b head=%0d empty=%0b",
                  want.head_valid, want.head_particle, want.old_box_empty,
                  got.head_valid, got.head_particle, got.old_box_empty));
         end
         beats++;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("cell_list_bucket_maintenance_test NOT OK");
         $finish;
      end
   end

endmodule

/* sim.f */
rtl/clbm_pkg.sv
rtl/clbm_req_if.sv
rtl/clbm_rsp_if.sv
rtl/clbm_ctrl.sv
rtl/clbm_dp.sv
rtl/cell_list_bucket_maintenance.sv
rtl/clbm_chk.sv
tb/cell_list_bucket_maintenance_test.sv
